[src/lsm_pkg.sv]
// ----------------------------------------------------------------------------
// lsm_pkg - shared definitions for the latency statistics monitor
// Sizes, opcodes, result kinds and the packed layouts of the entry and slot
// words held in the two state memories.
// ----------------------------------------------------------------------------
`default_nettype none

package lsm_pkg;

  localparam int unsigned ENTRY_COUNT  = 64;
  localparam int unsigned RECORD_SLOTS = 16;

  localparam int unsigned EW        = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int unsigned PW        = $clog2(RECORD_SLOTS);
  localparam int unsigned CW        = $clog2(RECORD_SLOTS + 1);
  localparam int unsigned TOTAL     = ENTRY_COUNT * RECORD_SLOTS;
  localparam int unsigned SW        = $clog2(TOTAL);

  // variance divide by RECORD_SLOTS-1: round-up reciprocal, exact for any
  // 32-bit dividend with this shift
  localparam int unsigned VAR_SHIFT = 32 + $clog2(RECORD_SLOTS - 1);
  localparam logic [33:0] VAR_RECIP =
    34'(((64'd1 << VAR_SHIFT) + 64'(RECORD_SLOTS - 2)) / 64'(RECORD_SLOTS - 1));
  localparam int unsigned VAR_PW    = VAR_SHIFT + 32;

  localparam logic [31:0] DEFAULT_MIN_INTERVAL = 32'd60000000;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_END   = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_e;

  localparam logic KIND_ALARM = 1'b0;
  localparam logic KIND_STATS = 1'b1;

  // per-entry word
  typedef struct packed {
    logic [PW-1:0] pos;
    logic [31:0]   max_us;
    logic [31:0]   min_us;
    logic [31:0]   thr_us;
    logic          latched;
  } entry_t;

  // per-slot word, begin time kept in its own array
  typedef struct packed {
    logic [31:0] end_us;
    logic [31:0] delta_us;
    logic        reported;
  } slot_t;

endpackage

`default_nettype wire

[src/lsm_slot_mem.sv]
// ----------------------------------------------------------------------------
// lsm_slot_mem - ring slot store
// Begin times and end/delta/reported words for every slot of every entry.
// One shared write address with separate enables, one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lsm_slot_mem (
  input  wire logic                 clk_i,
  input  wire logic [lsm_pkg::SW-1:0] wr_addr_i,
  input  wire logic                 wr_begin_en_i,
  input  wire logic [31:0]          wr_begin_i,
  input  wire logic                 wr_rest_en_i,
  input  wire lsm_pkg::slot_t       wr_rest_i,
  input  wire logic [lsm_pkg::SW-1:0] rd_addr_i,
  output      logic [31:0]          rd_begin_o,
  output      lsm_pkg::slot_t       rd_rest_o
);
  import lsm_pkg::*;

  logic [31:0] begin_mem [TOTAL];
  slot_t       rest_mem  [TOTAL];

  always_ff @(posedge clk_i) begin
    if (wr_begin_en_i) begin
      begin_mem[wr_addr_i] <= wr_begin_i;
    end
    if (wr_rest_en_i) begin
      rest_mem[wr_addr_i] <= wr_rest_i;
    end
    rd_begin_o <= begin_mem[rd_addr_i];
    rd_rest_o  <= rest_mem[rd_addr_i];
  end

endmodule

`default_nettype wire

[src/lsm_entry_mem.sv]
// ----------------------------------------------------------------------------
// lsm_entry_mem - per-entry store
// Ring position, running min/max, threshold and latch flag per entry.
// One write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lsm_entry_mem (
  input  wire logic                   clk_i,
  input  wire logic                   wr_en_i,
  input  wire logic [lsm_pkg::EW-1:0] wr_addr_i,
  input  wire lsm_pkg::entry_t        wr_data_i,
  input  wire logic [lsm_pkg::EW-1:0] rd_addr_i,
  output      lsm_pkg::entry_t        rd_data_o
);
  import lsm_pkg::*;

  entry_t mem [ENTRY_COUNT];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

`default_nettype wire

[src/lsm_div.sv]
// ----------------------------------------------------------------------------
// lsm_div - variance divider
// Divides by RECORD_SLOTS-1 with a registered reciprocal multiply; the
// quotient is ready in the cycle after start.
// ----------------------------------------------------------------------------
`default_nettype none

module lsm_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  output      logic        done_o,
  output      logic [31:0] quotient_o
);
  import lsm_pkg::*;

  logic              done_q;
  logic [VAR_PW-1:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= VAR_PW'(dividend_i) * VAR_PW'(VAR_RECIP);
    end
  end

  assign done_o     = done_q;
  assign quotient_o = prod_q[VAR_SHIFT +: 32];

endmodule

`default_nettype wire

[src/latency_stats_monitor.sv]
// ----------------------------------------------------------------------------
// latency_stats_monitor - per-entry latency tracker with alarms and stats
// Begin/end/clear events per entry; alarm reports and ring statistics out.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i/in_ready_o) takes one event word: opcode,
//    entry index, timestamp, threshold and result code. Output channel
//    (out_valid_o/out_ready_i) gives result words: alarm reports and
//    statistics records, at most two per event, last_o on the final one.
//  - cfg_we_i/cfg_data_i write the minimum report interval.
//  - One event is handled at a time. Begin: entry read, then the slot
//    begin time and entry write. Clear: entry clear and a write pass over
//    the slots of the ring. Ignored events leave the sequencer idle. End
//    mark: entry read, slot read and write-back, plus a scan of the ring
//    when an alarm is possible and the alarm word. A ring wrap adds a sum
//    pass, the mean, a variance pass, the reciprocal multiply and the record.
//    The passes are set by the single read port of the slot memory.
//  - After reset a clearing pass writes every slot and entry, one per
//    cycle, with in_ready_o low.
//  - The output word sits in its own register, so a new event is taken
//    while a result waits; the sequencer holds only when it has a word to
//    give and the previous one has not been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module latency_stats_monitor (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [5:0]  entry_index_i,
  input  wire logic [31:0] timestamp_us_i,
  input  wire logic [31:0] threshold_us_i,
  input  wire logic signed [31:0] result_code_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic        kind_o,
  output      logic [5:0]  entry_id_o,
  output      logic        last_o,
  output      logic [31:0] delta_us_o,
  output      logic signed [31:0] code_out_o,
  output      logic [31:0] threshold_out_o,
  output      logic [31:0] max_us_o,
  output      logic [31:0] min_us_o,
  output      logic [31:0] mean_us_o,
  output      logic [31:0] variance_out_o,
  output      logic [4:0]  sample_count_o
);
  import lsm_pkg::*;

  typedef enum logic [14:0] {
    S_INIT   = 15'h0001,
    S_IDLE   = 15'h0002,
    S_ERD    = 15'h0004,
    S_SRD    = 15'h0008,
    S_SCAN   = 15'h0010,
    S_WB     = 15'h0020,
    S_ALARM  = 15'h0040,
    S_SUM    = 15'h0080,
    S_MEAN   = 15'h0100,
    S_VAR    = 15'h0200,
    S_VFLUSH = 15'h0400,
    S_VSTART = 15'h0800,
    S_VDIV   = 15'h1000,
    S_STAT   = 15'h2000,
    S_CLR    = 15'h4000
  } state_e;

  state_e        state_q, state_d;
  logic [31:0]   interval_q;
  logic [1:0]    op_q, op_d;
  logic [EW-1:0] e_q, e_d;
  logic [31:0]   ts_q, ts_d, thr_in_q, thr_in_d, code_q, code_d;
  entry_t        ent_q, ent_d;
  logic [31:0]   delta_q, delta_d;
  logic          cand_q, cand_d, hit_q, hit_d, alarm_q, alarm_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          chk_vld_q, chk_vld_d;
  logic [PW-1:0] chk_idx_q, chk_idx_d;
  logic [31:0]   sum_q, sum_d, mean_q, mean_d, var_q, var_d, prod_q, prod_d;
  logic          prod_vld_q, prod_vld_d;
  logic [SW-1:0] init_q, init_d;

  // output register
  logic        out_vld_q, out_vld_d, out_load;
  logic        o_kind_d, o_last_d;
  logic [31:0] o_delta_d, o_code_d, o_thr_d, o_max_d, o_min_d, o_mean_d, o_var_d;
  logic [4:0]  o_cnt_d;
  logic        out_free;

  // memory ports
  logic [SW-1:0] s_waddr, s_raddr;
  logic          s_wbeg_en, s_wrest_en;
  slot_t         s_wrest, s_rrest;
  logic [31:0]   s_rbegin;
  logic          e_wen;
  logic [EW-1:0] e_waddr, e_raddr;
  entry_t        e_wdata, e_rdata;

  // variance divider
  logic        div_start, div_done;
  logic [31:0] div_dividend, div_quo;

  logic [SW-1:0] base;
  logic          accept, in_ok, wrap;
  logic [EW-1:0] e_in;
  logic [31:0]   new_delta, diff;
  logic [63:0]   sq;

  assign e_in     = EW'(entry_index_i);
  assign in_ok    = (32'(entry_index_i) < ENTRY_COUNT);
  assign base     = SW'(32'(e_q) * RECORD_SLOTS);
  assign in_ready_o = (state_q == S_IDLE);
  assign accept   = in_valid_i & in_ready_o;
  assign out_free = !out_vld_q || out_ready_i;
  assign wrap     = (ent_q.pos == PW'(RECORD_SLOTS - 1));
  assign new_delta = ts_q - s_rbegin;
  assign diff     = s_rrest.delta_us - mean_q;
  assign sq       = 64'(diff) * 64'(diff);
  assign div_dividend = var_q;

  lsm_slot_mem u_slot_mem (
    .clk_i         (clk_i),
    .wr_addr_i     (s_waddr),
    .wr_begin_en_i (s_wbeg_en),
    .wr_begin_i    (s_wbeg_en && state_q == S_ERD ? ts_q : 32'd0),
    .wr_rest_en_i  (s_wrest_en),
    .wr_rest_i     (s_wrest),
    .rd_addr_i     (s_raddr),
    .rd_begin_o    (s_rbegin),
    .rd_rest_o     (s_rrest)
  );

  lsm_entry_mem u_entry_mem (
    .clk_i     (clk_i),
    .wr_en_i   (e_wen),
    .wr_addr_i (e_waddr),
    .wr_data_i (e_wdata),
    .rd_addr_i (e_raddr),
    .rd_data_o (e_rdata)
  );

  lsm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign e_raddr = (state_q == S_IDLE) ? e_in : e_q;

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    e_d        = e_q;
    ts_d       = ts_q;
    thr_in_d   = thr_in_q;
    code_d     = code_q;
    ent_d      = ent_q;
    delta_d    = delta_q;
    cand_d     = cand_q;
    hit_d      = hit_q;
    alarm_d    = alarm_q;
    cnt_d      = cnt_q;
    chk_vld_d  = 1'b0;
    chk_idx_d  = cnt_q[PW-1:0];
    sum_d      = sum_q;
    mean_d     = mean_q;
    var_d      = var_q;
    prod_d     = sq[31:0];
    prod_vld_d = 1'b0;
    init_d     = init_q;

    s_raddr    = base + SW'(cnt_q[PW-1:0]);
    s_waddr    = base + SW'(ent_q.pos);
    s_wbeg_en  = 1'b0;
    s_wrest_en = 1'b0;
    s_wrest    = '0;
    e_wen      = 1'b0;
    e_waddr    = e_q;
    e_wdata    = '0;

    div_start  = 1'b0;

    out_load  = 1'b0;
    o_kind_d  = KIND_ALARM;
    o_last_d  = 1'b1;
    o_delta_d = '0;
    o_code_d  = '0;
    o_thr_d   = '0;
    o_max_d   = '0;
    o_min_d   = '0;
    o_mean_d  = '0;
    o_var_d   = '0;
    o_cnt_d   = '0;

    unique case (state_q)
      S_INIT: begin
        // clearing pass over all slots; entries share the low addresses
        s_waddr    = init_q;
        s_wbeg_en  = 1'b1;
        s_wrest_en = 1'b1;
        e_wen      = (32'(init_q) < ENTRY_COUNT);
        e_waddr    = EW'(init_q);
        init_d     = init_q + SW'(1);
        if (32'(init_q) == TOTAL - 1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_d     = opcode_i;
          e_d      = e_in;
          ts_d     = timestamp_us_i;
          thr_in_d = threshold_us_i;
          code_d   = result_code_i;
          if (in_ok && (opcode_i == OP_BEGIN || opcode_i == OP_END ||
                        opcode_i == OP_CLEAR)) begin
            state_d = S_ERD;
          end
        end
      end
      S_ERD: begin
        ent_d   = e_rdata;
        s_raddr = base + SW'(e_rdata.pos);
        s_waddr = base + SW'(e_rdata.pos);
        priority if (op_q == OP_BEGIN) begin
          s_wbeg_en = 1'b1;
          e_wen     = 1'b1;
          e_wdata   = e_rdata;
          if (!e_rdata.latched) begin
            e_wdata.thr_us  = thr_in_q;
            e_wdata.latched = 1'b1;
          end
          state_d = S_IDLE;
        end else if (op_q == OP_END) begin
          state_d = S_SRD;
        end else begin
          e_wen   = 1'b1;
          cnt_d   = '0;
          state_d = S_CLR;
        end
      end
      S_SRD: begin
        delta_d = new_delta;
        if (ent_q.pos == '0) begin
          ent_d.max_us = new_delta;
          ent_d.min_us = new_delta;
        end else begin
          if (ent_q.max_us < new_delta) ent_d.max_us = new_delta;
          if (ent_q.min_us > new_delta) ent_d.min_us = new_delta;
        end
        cand_d = (ent_q.thr_us != '0) && (code_q != '0 || new_delta > ent_q.thr_us);
        hit_d  = 1'b0;
        cnt_d  = '0;
        state_d = (cand_d) ? S_SCAN : S_WB;
      end
      S_SCAN: begin
        // look for another slot that reported within the interval
        if (32'(cnt_q) < RECORD_SLOTS) begin
          chk_vld_d = 1'b1;
          cnt_d     = cnt_q + CW'(1);
        end else begin
          state_d = S_WB;
        end
        if (chk_vld_q && chk_idx_q != ent_q.pos && s_rrest.reported &&
            (ts_q - s_rrest.end_us) < interval_q) begin
          hit_d = 1'b1;
        end
      end
      S_WB: begin
        alarm_d             = cand_q && !hit_q;
        s_wrest_en          = 1'b1;
        s_wrest.end_us      = ts_q;
        s_wrest.delta_us    = delta_q;
        s_wrest.reported    = cand_q && !hit_q;
        e_wen               = 1'b1;
        e_wdata             = ent_q;
        e_wdata.pos         = wrap ? '0 : ent_q.pos + PW'(1);
        cnt_d               = '0;
        sum_d               = '0;
        priority if (cand_q && !hit_q) state_d = S_ALARM;
        else if (wrap)                 state_d = S_SUM;
        else                           state_d = S_IDLE;
      end
      S_ALARM: begin
        if (out_free) begin
          out_load  = 1'b1;
          o_kind_d  = KIND_ALARM;
          o_last_d  = !wrap;
          o_delta_d = delta_q;
          o_code_d  = code_q;
          o_thr_d   = ent_q.thr_us;
          state_d   = wrap ? S_SUM : S_IDLE;
        end
      end
      S_SUM: begin
        if (32'(cnt_q) < RECORD_SLOTS) begin
          chk_vld_d = 1'b1;
          cnt_d     = cnt_q + CW'(1);
        end else begin
          state_d = S_MEAN;
        end
        if (chk_vld_q) sum_d = sum_q + s_rrest.delta_us;
      end
      S_MEAN: begin
        // slot count is a power of two, so this is a shift
        mean_d  = sum_q / RECORD_SLOTS;
        var_d   = '0;
        cnt_d   = '0;
        state_d = S_VAR;
      end
      S_VAR: begin
        if (32'(cnt_q) < RECORD_SLOTS) begin
          chk_vld_d = 1'b1;
          cnt_d     = cnt_q + CW'(1);
        end else begin
          state_d = S_VFLUSH;
        end
        prod_vld_d = chk_vld_q;
        if (prod_vld_q) var_d = var_q + prod_q;
      end
      S_VFLUSH: begin
        if (prod_vld_q) var_d = var_q + prod_q;
        state_d = S_VSTART;
      end
      S_VSTART: begin
        div_start = 1'b1;
        state_d   = S_VDIV;
      end
      S_VDIV: begin
        if (div_done) begin
          var_d   = div_quo;
          state_d = S_STAT;
        end
      end
      S_STAT: begin
        if (out_free) begin
          out_load = 1'b1;
          o_kind_d = KIND_STATS;
          o_last_d = 1'b1;
          o_max_d  = ent_q.max_us;
          o_min_d  = ent_q.min_us;
          o_mean_d = mean_q;
          o_var_d  = var_q;
          o_cnt_d  = 5'(RECORD_SLOTS);
          state_d  = S_IDLE;
        end
      end
      S_CLR: begin
        s_waddr    = base + SW'(cnt_q[PW-1:0]);
        s_wbeg_en  = 1'b1;
        s_wrest_en = 1'b1;
        cnt_d      = cnt_q + CW'(1);
        if (32'(cnt_q) == RECORD_SLOTS - 1) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    out_vld_d = out_load ? 1'b1 : (out_vld_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      init_q     <= '0;
      interval_q <= DEFAULT_MIN_INTERVAL;
      out_vld_q  <= 1'b0;
      cnt_q      <= '0;
      chk_vld_q  <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      init_q     <= init_d;
      out_vld_q  <= out_vld_d;
      cnt_q      <= cnt_d;
      chk_vld_q  <= chk_vld_d;
      prod_vld_q <= prod_vld_d;
      if (cfg_we_i) interval_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    e_q       <= e_d;
    ts_q      <= ts_d;
    thr_in_q  <= thr_in_d;
    code_q    <= code_d;
    ent_q     <= ent_d;
    delta_q   <= delta_d;
    cand_q    <= cand_d;
    hit_q     <= hit_d;
    alarm_q   <= alarm_d;
    chk_idx_q <= chk_idx_d;
    sum_q     <= sum_d;
    mean_q    <= mean_d;
    var_q     <= var_d;
    prod_q    <= prod_d;
    if (out_load) begin
      kind_o          <= o_kind_d;
      entry_id_o      <= 6'(e_q);
      last_o          <= o_last_d;
      delta_us_o      <= o_delta_d;
      code_out_o      <= o_code_d;
      threshold_out_o <= o_thr_d;
      max_us_o        <= o_max_d;
      min_us_o        <= o_min_d;
      mean_us_o       <= o_mean_d;
      variance_out_o  <= o_var_d;
      sample_count_o  <= o_cnt_d;
    end
  end

  assign out_valid_o = out_vld_q;

  // an unused opcode never occupies the sequencer
  a_op_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && opcode_i == 2'd3) |=> in_ready_o)
    else $error("unused opcode held the input");

  // a statistics record always closes the event
  a_stats_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_STATS) |-> (last_o && delta_us_o == '0))
    else $error("statistics record malformed");

  // an alarm is only issued once the slot write-back has recorded it
  a_alarm_after_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ALARM) |-> alarm_q)
    else $error("alarm state without alarm flag");

endmodule

`default_nettype wire
